>>> src/pca_pkg.sv
// ----------------------------------------------------------------------------
// pca_pkg
// Types, widths and codes shared by the pinned core assigner files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

  localparam int CORE_W    = 6;
  localparam int CNT_W     = 7;
  localparam int MASK_W    = 64;
  localparam int THREAD_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int CORE_MAX  = 64;

  typedef logic [CORE_W-1:0] core_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam logic MODE_ASSIGN = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORE_COUNT = 2'd0,
    REG_INTERLEAVE = 2'd1,
    REG_ALLOWED    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RES_PINNED = 2'd0,
    RES_CHOSEN = 2'd1,
    RES_FAULT  = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_LOOKUP = 3'd1,
    ST_DECIDE = 3'd2,
    ST_CHECK  = 3'd3,
    ST_WALK   = 3'd4,
    ST_PREP   = 3'd5,
    ST_FINAL  = 3'd6,
    ST_RESULT = 3'd7
  } pca_state_t;

  typedef struct packed {
    logic      latch;
    logic      write_pin;
    logic      init_search;
    logic      walk_init;
    logic      walk_step;
    logic      take_walk;
    logic      cand_first;
    logic      set_ptr;
    logic      res_set;
    res_kind_t res_kind;
    logic      out_load;
  } pca_cmd_t;

  typedef struct packed {
    logic mode_load;
    logic pinned;
    logic mask_empty;
    logic cand_ok;
    logic walk_hit;
    logic walk_at_first;
    logic walk_done;
    logic iter_done;
    logic out_free;
  } pca_sts_t;

endpackage

`default_nettype wire

>>> src/pca_in_if.sv
// ----------------------------------------------------------------------------
// pca_in_if
// Input item channel: assign or pin-load request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pca_in_if import pca_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [THREAD_W-1:0] thread_num;
  core_t               pin_core;
  mask_t               busy_cores;

  modport source (output valid, mode, thread_num, pin_core, busy_cores, input ready);
  modport sink   (input valid, mode, thread_num, pin_core, busy_cores, output ready);
endinterface

`default_nettype wire

>>> src/pca_out_if.sv
// ----------------------------------------------------------------------------
// pca_out_if
// Result channel: chosen core and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pca_out_if import pca_pkg::*; ();
  logic  valid;
  logic  ready;
  core_t chosen_core;
  logic  was_pinned;
  logic  no_allowed_core;

  modport source (output valid, chosen_core, was_pinned, no_allowed_core, input ready);
  modport sink   (input valid, chosen_core, was_pinned, no_allowed_core, output ready);
endinterface

`default_nettype wire

>>> src/pca_cfg_if.sv
// ----------------------------------------------------------------------------
// pca_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pca_cfg_if import pca_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/pinned_core_assigner_top.sv
// ----------------------------------------------------------------------------
// pinned_core_assigner_top
// Places each new thread on a pinned core or on the next free allowed core.
// ----------------------------------------------------------------------------
// load beat: pin written in lookup, no result; pinned assign or empty mask: result staged
// in decide, then loaded into the output register from the result state once it is free
// unpinned: candidate checks, walker steps and a prep step on fallback to the start core
// walker steps: a few typically, up to about cores*(cores+1) with sparse masks
// one item at a time; the next beat is taken while a result waits in the output register
// reset: pin valid bits and pointer cleared, config to defaults at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module pinned_core_assigner_top import pca_pkg::*; #(
  parameter int THREAD_SLOTS = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pca_in_if.sink    in_ch,
  pca_out_if.source out_ch,
  pca_cfg_if.sink   cfg_ch
);

  pca_cmd_t cmd;
  pca_sts_t sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  pca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pca_dp #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_ch.mode),
    .in_thread_num (in_ch.thread_num),
    .in_pin_core   (in_ch.pin_core),
    .in_busy_cores (in_ch.busy_cores),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

`default_nettype wire

>>> src/pca_ctrl.sv
// ----------------------------------------------------------------------------
// pca_ctrl
// Sequencer for lookup, candidate search and pointer update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pca_ctrl import pca_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire pca_sts_t sts,
  output pca_cmd_t      cmd
);

  pca_state_t state_r;
  pca_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.mode_load) begin
          cmd.write_pin = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.pinned) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_PINNED;
          state_nxt    = ST_RESULT;
        end else if (sts.mask_empty) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_FAULT;
          state_nxt    = ST_RESULT;
        end else begin
          cmd.init_search = 1'b1;
          state_nxt       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.walk_init = 1'b1;
        state_nxt     = sts.cand_ok ? ST_FINAL : ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_hit) begin
          if (sts.walk_at_first || sts.iter_done) begin
            cmd.cand_first = 1'b1;
            state_nxt      = ST_PREP;
          end else begin
            cmd.take_walk = 1'b1;
            state_nxt     = ST_CHECK;
          end
        end else if (sts.walk_done) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_FAULT;
          state_nxt    = ST_RESULT;
        end
      end
      ST_PREP: begin
        cmd.walk_init = 1'b1;
        state_nxt     = ST_FINAL;
      end
      ST_FINAL: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_hit) begin
          cmd.set_ptr  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_CHOSEN;
          state_nxt    = ST_RESULT;
        end else if (sts.walk_done) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_FAULT;
          state_nxt    = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == ST_IDLE)
    else $error("result load not followed by idle");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> !in_ready)
    else $error("new beat taken while an item is in flight");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_set |-> !cmd.out_load)
    else $error("result staged and loaded in one cycle");

endmodule

`default_nettype wire

>>> src/pca_dp.sv
// ----------------------------------------------------------------------------
// pca_dp
// Datapath: pin table, config registers, candidate walker, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pca_dp import pca_pkg::*; #(
  parameter int THREAD_SLOTS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_mode,
  input  wire logic [THREAD_W-1:0] in_thread_num,
  input  wire core_t         in_pin_core,
  input  wire mask_t         in_busy_cores,
  pca_out_if.source          out_ch,
  pca_cfg_if.sink            cfg_ch,
  input  wire pca_cmd_t      cmd,
  output pca_sts_t           sts
);

  localparam int SLOT_DEPTH = (THREAD_SLOTS < 256) ? THREAD_SLOTS : 256;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);

  function automatic logic [SLOT_W-1:0] slot_of(input logic [THREAD_W-1:0] t);
    logic [15:0] r;
    logic [15:0] d;
    r = 16'(t);
    for (int k = 7; k >= 0; k--) begin
      d = 16'(SLOT_DEPTH) << k;
      if (r >= d) r = r - d;
    end
    return r[SLOT_W-1:0];
  endfunction

  function automatic core_t adv(input core_t w, input cnt_t step, input cnt_t cores);
    cnt_t s;
    cnt_t v;
    s = {1'b0, w} + step;
    if (s >= cores) begin
      v = s - cores + 7'd1;
      if (v == step) v = '0;
    end else begin
      v = s;
    end
    return v[CORE_W-1:0];
  endfunction

  // config registers
  cnt_t  cc_r;
  cnt_t  il_r;
  mask_t allow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= 7'd64;
      il_r    <= 7'd1;
      allow_r <= '1;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_CORE_COUNT: cc_r    <= cfg_ch.data[CNT_W-1:0];
        REG_INTERLEAVE: il_r    <= cfg_ch.data[CNT_W-1:0];
        REG_ALLOWED:    allow_r <= cfg_ch.data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // effective settings
  cnt_t  eff_cores;
  cnt_t  eff_step;
  mask_t eff_mask;
  core_t eff_first;
  core_t nsc_r;

  always_comb begin
    if (cc_r == '0) begin
      eff_cores = 7'd1;
    end else if (cc_r > 7'(CORE_MAX)) begin
      eff_cores = 7'(CORE_MAX);
    end else begin
      eff_cores = cc_r;
    end
    if (il_r == '0) begin
      eff_step = 7'd1;
    end else if (il_r > eff_cores) begin
      eff_step = eff_cores;
    end else begin
      eff_step = il_r;
    end
    if (eff_cores >= 7'(CORE_MAX)) begin
      eff_mask = allow_r;
    end else begin
      eff_mask = allow_r & ((64'd1 << eff_cores) - 64'd1);
    end
    eff_first = ({1'b0, nsc_r} >= eff_cores) ? '0 : nsc_r;
  end

  // item registers
  logic              mode_r;
  logic [SLOT_W-1:0] slot_r;
  core_t             pin_r;
  mask_t             busy_r;
  cnt_t              cores_r;
  cnt_t              step_r;
  mask_t             mask_r;
  core_t             first_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r  <= in_mode;
      slot_r  <= slot_of(in_thread_num);
      pin_r   <= in_pin_core;
      busy_r  <= in_busy_cores;
      cores_r <= eff_cores;
      step_r  <= eff_step;
      mask_r  <= eff_mask;
      first_r <= eff_first;
    end
  end

  // pin table
  core_t                 pin_table [SLOT_DEPTH];
  core_t                 pin_q_r;
  logic [SLOT_DEPTH-1:0] pin_vld_r;
  logic                  pin_hit_r;

  always_ff @(posedge clk) begin
    if (cmd.write_pin) begin
      pin_table[slot_r] <= pin_r;
    end
    pin_q_r <= pin_table[slot_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_vld_r <= '0;
      pin_hit_r <= 1'b0;
    end else begin
      if (cmd.write_pin) begin
        pin_vld_r[slot_r] <= 1'b1;
      end
      pin_hit_r <= pin_vld_r[slot_r];
    end
  end

  // candidate walker
  core_t cand_r;
  core_t w_r;
  cnt_t  i_r;
  cnt_t  j_r;
  core_t walk_w;

  assign walk_w = adv(w_r, step_r, cores_r);

  always_ff @(posedge clk) begin
    if (cmd.init_search) begin
      cand_r <= first_r;
      i_r    <= '0;
    end else if (cmd.take_walk) begin
      cand_r <= walk_w;
      i_r    <= i_r + 7'd1;
    end else if (cmd.cand_first) begin
      cand_r <= first_r;
    end
    if (cmd.walk_init) begin
      w_r <= cand_r;
      j_r <= '0;
    end else if (cmd.walk_step) begin
      w_r <= walk_w;
      j_r <= j_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nsc_r <= '0;
    end else if (cmd.set_ptr) begin
      nsc_r <= walk_w;
    end
  end

  // result staging and output register
  core_t res_core_r;
  logic  res_pin_r;
  logic  res_fault_r;
  logic  out_valid_r;
  core_t out_core_r;
  logic  out_pin_r;
  logic  out_fault_r;

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      case (cmd.res_kind)
        RES_PINNED: begin
          res_core_r  <= pin_q_r;
          res_pin_r   <= 1'b1;
          res_fault_r <= 1'b0;
        end
        RES_CHOSEN: begin
          res_core_r  <= cand_r;
          res_pin_r   <= 1'b0;
          res_fault_r <= 1'b0;
        end
        default: begin
          res_core_r  <= '0;
          res_pin_r   <= 1'b0;
          res_fault_r <= 1'b1;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_core_r  <= res_core_r;
      out_pin_r   <= res_pin_r;
      out_fault_r <= res_fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.chosen_core     = out_core_r;
  assign out_ch.was_pinned      = out_pin_r;
  assign out_ch.no_allowed_core = out_fault_r;

  // status
  always_comb begin
    sts               = '0;
    sts.mode_load     = (mode_r == MODE_LOAD);
    sts.pinned        = pin_hit_r;
    sts.mask_empty    = (mask_r == '0);
    sts.cand_ok       = mask_r[cand_r] & ~busy_r[cand_r];
    sts.walk_hit      = mask_r[walk_w];
    sts.walk_at_first = (walk_w == first_r);
    sts.walk_done     = ((j_r + 7'd1) == cores_r);
    sts.iter_done     = ((i_r + 7'd1) == cores_r);
    sts.out_free      = !out_valid_r || out_ch.ready;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten before it was taken");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> ({1'b0, w_r} < cores_r && j_r < cores_r))
    else $error("walker left the core range");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_ptr |=> ({1'b0, nsc_r} < cores_r && mask_r[nsc_r]))
    else $error("pointer moved to a core that is not allowed");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.no_allowed_core) |->
      (out_ch.chosen_core == '0 && !out_ch.was_pinned))
    else $error("fault result carries a core");

endmodule

`default_nettype wire
